// File: rtl/u8csf_pkg.sv
`timescale 1ns / 1ps
package u8csf_pkg;

   localparam int WinDepth = 4;

   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic drop;
      logic start_emit;
      logic emit;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic [2:0] lead_len;
      logic [2:0] win_cnt;
      logic       cont_ok;
      logic       move_ok;
      logic       emit_last;
   } status_type;

   // sequence length from the lead byte, zero when it cannot lead
   function automatic logic [2:0] seq_length(input logic [7:0] c);
      logic [2:0] len;
      if ((c & 8'h80) == 8'h00) begin
         len = 3'd1;
      end else if ((c & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((c & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((c & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

endpackage

// File: rtl/u8csf_ctrl.sv
`timescale 1ns / 1ps
module u8csf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_clear,
   input  u8csf_pkg::status_type status,
   output logic                  req_stall,
   output u8csf_pkg::state_type  state,
   output u8csf_pkg::cmd_type    cmd
);

   u8csf_pkg::state_type state_ff;
   u8csf_pkg::state_type state_in;
   logic                 seq_done;
   logic                 seq_bad;

   assign seq_done = (status.win_cnt == 3'd0) ||
                     ((status.lead_len != 3'd0) && (status.lead_len > status.win_cnt));
   assign seq_bad  = (status.lead_len == 3'd0) || !status.cont_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8csf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         u8csf_pkg::ST_IDLE: begin
            if (req_valid && !req_clear) begin
               state_in = u8csf_pkg::ST_SCAN;
            end
         end
         u8csf_pkg::ST_SCAN: begin
            if (seq_done) begin
               if (status.move_ok) begin
                  state_in = u8csf_pkg::ST_IDLE;
               end
            end else if (!seq_bad) begin
               state_in = u8csf_pkg::ST_EMIT;
            end
         end
         u8csf_pkg::ST_EMIT: begin
            if (status.move_ok && status.emit_last) begin
               state_in = u8csf_pkg::ST_SCAN;
            end
         end
         default: state_in = u8csf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         u8csf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid && !req_clear;
            cmd.clear = req_valid && req_clear;
         end
         u8csf_pkg::ST_SCAN: begin
            if (seq_done) begin
               cmd.flush = status.move_ok;
            end else if (seq_bad) begin
               cmd.drop = 1'b1;
            end else begin
               cmd.start_emit = 1'b1;
            end
         end
         u8csf_pkg::ST_EMIT: begin
            cmd.emit = status.move_ok;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// File: rtl/u8csf_dp.sv
`timescale 1ns / 1ps
module u8csf_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              in_byte,
   input  u8csf_pkg::cmd_type      cmd,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output u8csf_pkg::rsp_item_type rsp_data,
   output u8csf_pkg::status_type   status
);

   logic [7:0]              win_ff [u8csf_pkg::WinDepth];
   logic [7:0]              win_in [u8csf_pkg::WinDepth];
   logic [2:0]              cnt_ff;
   logic [2:0]              cnt_in;
   logic [2:0]              emit_cnt_ff;
   logic [2:0]              emit_cnt_in;
   logic [7:0]              pend_byte_ff;
   logic [7:0]              pend_byte_in;
   logic                    pend_valid_ff;
   logic                    pend_valid_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   u8csf_pkg::rsp_item_type rsp_data_ff;
   u8csf_pkg::rsp_item_type rsp_data_in;
   logic [2:0]              lead_len;
   logic                    cont_ok;

   assign lead_len = u8csf_pkg::seq_length(win_ff[0]);

   always_comb begin
      cont_ok = 1'b1;
      for (int i = 1; i < u8csf_pkg::WinDepth; i++) begin
         if ((3'(i) < lead_len) && (win_ff[i][7:6] != 2'b10)) begin
            cont_ok = 1'b0;
         end
      end
   end

   always_comb begin
      win_in        = win_ff;
      cnt_in        = cnt_ff;
      emit_cnt_in   = emit_cnt_ff;
      pend_byte_in  = pend_byte_ff;
      pend_valid_in = pend_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.clear) begin
         cnt_in = 3'd0;
      end
      if (cmd.load) begin
         win_in[cnt_ff[1:0]] = in_byte;
         cnt_in              = cnt_ff + 3'd1;
      end
      if (cmd.drop || cmd.emit) begin
         for (int i = 0; i < u8csf_pkg::WinDepth - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
      if (cmd.start_emit) begin
         emit_cnt_in = lead_len;
      end
      // one byte of lookahead so the last byte of the request gets its flag
      if (cmd.emit) begin
         emit_cnt_in   = emit_cnt_ff - 3'd1;
         pend_byte_in  = win_ff[0];
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_data_in  = '{out_byte: pend_byte_ff, last_of_run: 1'b0};
            rsp_valid_in = 1'b1;
         end
      end
      if (cmd.flush && pend_valid_ff) begin
         rsp_data_in   = '{out_byte: pend_byte_ff, last_of_run: 1'b1};
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= 3'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      emit_cnt_ff  <= emit_cnt_in;
      pend_byte_ff <= pend_byte_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign status.lead_len  = lead_len;
   assign status.win_cnt   = cnt_ff;
   assign status.cont_ok   = cont_ok;
   assign status.move_ok   = !pend_valid_ff || !rsp_valid_ff || !rsp_stall;
   assign status.emit_last = (emit_cnt_ff == 3'd1);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/utf8_complete_sequence_filter_top.sv
`timescale 1ns / 1ps
// UTF-8 complete-sequence filter. Each data request appends one byte to a
// window of up to four bytes (the held partial sequence plus the new byte);
// a sequencer then walks that window one step per cycle unless rsp_stall
// holds it: checking a lead, dropping a byte that cannot lead or whose
// sequence has a bad continuation, or releasing one byte of a good sequence.
// Released bytes leave in stream order, last_of_run marks the final byte
// released by a request. A clear request empties the window and produces
// nothing. A data byte is taken while idle; scan checks the lead, emit
// releases each byte of a complete sequence and goes back to scan, and a
// scan with no complete sequence left returns to idle, each dropped byte
// adding a scan step. The result register lets the next request be taken
// while the final byte of the previous one waits on rsp_stall.
module utf8_complete_sequence_filter_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  u8csf_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output u8csf_pkg::rsp_item_type rsp_data
);

   u8csf_pkg::cmd_type    cmd;
   u8csf_pkg::status_type dp_status;
   u8csf_pkg::state_type  state;
   logic                  req_clear;

   assign req_clear = (req_data.req_type == u8csf_pkg::REQ_CLEAR);

   u8csf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_clear (req_clear),
      .status    (dp_status),
      .req_stall (req_stall),
      .state     (state),
      .cmd       (cmd)
   );

   u8csf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (req_data.in_byte),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (dp_status)
   );

   // held tail never exceeds three bytes between requests
   a_held_fits: assert property (@(posedge clock) disable iff (reset)
      (state == u8csf_pkg::ST_IDLE) |-> (dp_status.win_cnt != 3'd4))
      else $error("held tail too long");

   // a data request always starts a scan
   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_clear) |=> req_stall)
      else $error("data request did not start a scan");

   // a clear request empties the held bytes
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_clear) |=> (dp_status.win_cnt == 3'd0))
      else $error("clear left held bytes");

   // bytes are released only from a complete sequence
   a_emit_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.start_emit |-> (dp_status.lead_len != 3'd0 &&
                          dp_status.lead_len <= dp_status.win_cnt && dp_status.cont_ok))
      else $error("release of an incomplete sequence");

endmodule
